// File: src/shbf_pkg.sv
`default_nettype none

package shbf_pkg;

    localparam int BUCKETS_DEF    = 1024;
    localparam int MAX_POINTS_DEF = 4096;

    localparam logic [30:0] GRID_INTERVAL_RST = 31'd6554;
    localparam logic [10:0] BUCKET_COUNT_RST  = 11'd100;

    localparam logic CFG_GRID_INTERVAL = 1'b0;
    localparam logic CFG_BUCKET_COUNT  = 1'b1;

    localparam logic [31:0] PRIME_X = 32'd73856093;
    localparam logic [31:0] PRIME_Y = 32'd19349669;
    localparam logic [31:0] PRIME_Z = 32'd83492791;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               start_set;
    } t_point_in;

    typedef struct packed {
        logic [11:0] point_index;
        logic [9:0]  bucket;
        logic [11:0] slot;
        logic        overflow;
    } t_bucket_out;

    function automatic logic [31:0] axis_prime(input logic [1:0] axis);
        logic [31:0] p;
        unique case (axis)
            2'd0:    p = PRIME_X;
            2'd1:    p = PRIME_Y;
            2'd2:    p = PRIME_Z;
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// File: src/spatial_hash_bucket_fill_core.sv
// A point with start_set high first runs a sweep that clears the fill counts.
// The core takes one point at a time; busy stays high for the whole item.
// Three coordinate divisions and the bucket modulo run in turn on the shared restoring
// divider, and the result beat cannot be stalled.
// Reset is synchronous; afterwards a clearing sweep runs with busy high.
`default_nettype none

module spatial_hash_bucket_fill_core #(
    parameter int BUCKETS    = shbf_pkg::BUCKETS_DEF,
    parameter int MAX_POINTS = shbf_pkg::MAX_POINTS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire shbf_pkg::t_point_in    i_point,
    output logic                        o_result_valid,
    output shbf_pkg::t_bucket_out       o_result,
    input  wire logic                   i_cfg_we,
    input  wire logic                   i_cfg_idx,
    input  wire logic [30:0]            i_cfg_wdata
);

    import shbf_pkg::*;

    localparam int AW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int PW = $clog2(MAX_POINTS + 1);
    localparam logic [30:0]   BUCKETS_W  = 31'(BUCKETS);
    localparam logic [PW-1:0] MAX_W      = PW'(MAX_POINTS);
    localparam logic [AW-1:0] LAST_ADDR  = AW'(BUCKETS - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLEAR = 4'd1;
    localparam logic [3:0] S_PREP  = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_ROUND = 4'd4;
    localparam logic [3:0] S_NEG   = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_ACC   = 4'd7;
    localparam logic [3:0] S_MOD   = 4'd8;
    localparam logic [3:0] S_RD    = 4'd9;
    localparam logic [3:0] S_WR    = 4'd10;

    logic [3:0]    r_state;
    logic [30:0]   r_grid;
    logic [10:0]   r_bcount;
    t_point_in     r_point;
    logic [1:0]    r_axis;
    logic [31:0]   r_mag;
    logic [31:0]   r_cell;
    logic [31:0]   r_prod;
    logic [31:0]   r_hash;
    logic [AW-1:0] r_clr_addr;
    logic          r_clr_run;
    logic [AW-1:0] r_bucket;
    logic [9:0]    r_bucket_out;
    logic [PW-1:0] r_pcnt;
    logic [PW-1:0] r_rdata;
    logic          r_valid;
    t_bucket_out   r_out;

    logic [PW-1:0] fill_mem [BUCKETS];

    logic [30:0]   grid_eff;
    logic [30:0]   mod_eff;
    logic [31:0]   coord;
    logic          coord_neg;
    logic [31:0]   coord_mag;
    logic          div_start;
    logic [31:0]   div_dividend;
    logic [30:0]   div_divisor;
    logic          div_done;
    logic [31:0]   div_quo;
    logic [30:0]   div_rem;
    logic [31:0]   rem2;
    logic          round_up;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [PW-1:0] mem_wdata;
    logic          accept;

    always_comb begin
        grid_eff = (r_grid == '0) ? 31'd1 : r_grid;
        if (r_bcount == '0) begin
            mod_eff = 31'd1;
        end else if (31'(r_bcount) > BUCKETS_W) begin
            mod_eff = BUCKETS_W;
        end else begin
            mod_eff = 31'(r_bcount);
        end
    end

    always_comb begin
        unique case (r_axis)
            2'd0:    coord = r_point.pos_x;
            2'd1:    coord = r_point.pos_y;
            default: coord = r_point.pos_z;
        endcase
        coord_neg = coord[31];
        coord_mag = coord_neg ? (~coord + 32'd1) : coord;
    end

    always_comb begin
        div_start    = (r_state == S_PREP);
        div_dividend = (r_axis == 2'd3) ? r_hash : coord_mag;
        div_divisor  = (r_axis == 2'd3) ? mod_eff : grid_eff;
        rem2         = {div_rem, 1'b0};
        round_up     = (rem2 > {1'b0, grid_eff})
                    || ((rem2 == {1'b0, grid_eff}) && div_quo[0]);
    end

    shbf_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign accept = start && !busy;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_bucket;
        mem_wdata = r_rdata + PW'(1);
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else if (r_state == S_WR && r_pcnt < MAX_W) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            fill_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= fill_mem[r_bucket];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid   <= GRID_INTERVAL_RST;
            r_bcount <= BUCKET_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRID_INTERVAL: r_grid   <= i_cfg_wdata;
                CFG_BUCKET_COUNT:  r_bcount <= i_cfg_wdata[10:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_clr_run  <= 1'b0;
            r_pcnt     <= '0;
            r_valid    <= 1'b0;
            r_axis     <= '0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_axis <= '0;
                        if (i_point.start_set) begin
                            r_pcnt     <= '0;
                            r_clr_addr <= '0;
                            r_clr_run  <= 1'b1;
                            r_state    <= S_CLEAR;
                        end else begin
                            r_state <= S_PREP;
                        end
                    end
                end
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == LAST_ADDR) begin
                        r_state <= r_clr_run ? S_PREP : S_IDLE;
                    end
                end
                S_PREP: begin
                    r_state <= (r_axis == 2'd3) ? S_MOD : S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: r_state <= S_NEG;
                S_NEG:   r_state <= S_MUL;
                S_MUL:   r_state <= S_ACC;
                S_ACC: begin
                    r_axis  <= r_axis + 2'd1;
                    r_state <= S_PREP;
                end
                S_MOD: begin
                    if (div_done) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_WR;
                S_WR: begin
                    r_valid <= 1'b1;
                    if (r_pcnt < MAX_W) begin
                        r_pcnt <= r_pcnt + PW'(1);
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_point <= i_point;
            r_hash  <= '0;
        end
        if (r_state == S_ROUND) begin
            r_mag <= div_quo + 32'(round_up);
        end
        if (r_state == S_NEG) begin
            r_cell <= coord_neg ? (~r_mag + 32'd1) : r_mag;
        end
        if (r_state == S_MUL) begin
            r_prod <= 32'(r_cell * axis_prime(r_axis));
        end
        if (r_state == S_ACC) begin
            r_hash <= r_hash + r_prod;
        end
        if (r_state == S_MOD && div_done) begin
            r_bucket     <= div_rem[AW-1:0];
            r_bucket_out <= div_rem[9:0];
        end
        if (r_state == S_WR) begin
            r_out.bucket <= r_bucket_out;
            if (r_pcnt < MAX_W) begin
                r_out.point_index <= 12'(r_pcnt);
                r_out.slot        <= 12'(r_rdata);
                r_out.overflow    <= 1'b0;
            end else begin
                r_out.point_index <= '0;
                r_out.slot        <= '0;
                r_out.overflow    <= 1'b1;
            end
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_valid;
    assign o_result       = r_out;

endmodule

`default_nettype wire

// File: src/shbf_divider.sv
`default_nettype none

module shbf_divider (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [30:0] i_divisor,
    output logic             o_done,
    output logic [31:0]      o_quotient,
    output logic [30:0]      o_remainder
);

    logic [31:0] r_quo;
    logic [31:0] r_rem;
    logic [30:0] r_div;
    logic [4:0]  r_cnt;
    logic        r_run;
    logic        r_done;

    logic [31:0] trial;
    logic        fits;

    always_comb begin
        trial = {r_rem[30:0], r_quo[31]};
        fits  = trial >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_run) begin
            r_quo <= {r_quo[30:0], fits};
            r_rem <= fits ? trial - {1'b0, r_div} : trial;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem[30:0];

endmodule

`default_nettype wire

// File: src/shbf_checker.sv
`default_nettype none

module shbf_checker (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  start,
    input wire logic                  busy,
    input wire logic                  o_result_valid,
    input wire shbf_pkg::t_bucket_out o_result
);

    import shbf_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("busy low after reset");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (!busy && $past(busy)))
        else $error("result beat outside the end of an item");

    a_overflow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.overflow)
            |-> (o_result.point_index == '0 && o_result.slot == '0))
        else $error("overflow beat carries nonzero index or slot");

    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.overflow)
            |-> (o_result.slot <= o_result.point_index))
        else $error("slot exceeds point index");

endmodule

bind spatial_hash_bucket_fill_core shbf_checker u_shbf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);

`default_nettype wire

// File: verif/tb_top.sv
module tb_top;
    import shbf_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int TAIL_CYCLES = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_point_in   i_point = '0;
    logic        o_result_valid;
    t_bucket_out o_result;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_GRID_INTERVAL;
    logic [30:0] i_cfg_wdata = '0;

    logic [30:0] grid_reg = GRID_INTERVAL_RST;
    logic [10:0] bcount_reg = BUCKET_COUNT_RST;
    int unsigned fill_count [BUCKETS_DEF];
    int unsigned set_count = 0;
    t_bucket_out pending_buckets [$];
    t_bucket_out head;
    int          mismatch_count = 0;
    int          idle_pct = 0;
    int unsigned cycle_count = 0;

    spatial_hash_bucket_fill_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_point        (i_point),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // Signed division with rounding to nearest, ties to even.
    function automatic logic [31:0] round_cell(logic [31:0] raw, logic [31:0] div);
        logic [31:0] mag;
        logic [31:0] q;
        logic [31:0] r;
        mag = raw[31] ? (~raw + 32'd1) : raw;
        q = mag / div;
        r = mag % div;
        if ({r, 1'b0} > {1'b0, div} || ({r, 1'b0} == {1'b0, div} && q[0])) begin
            q = q + 32'd1;
        end
        return raw[31] ? (~q + 32'd1) : q;
    endfunction

    function automatic t_bucket_out predict_bucket(t_point_in p);
        logic [31:0] div;
        logic [31:0] h;
        int unsigned modulus;
        t_bucket_out r;
        div = (grid_reg == '0) ? 32'd1 : {1'b0, grid_reg};
        if (bcount_reg == '0) begin
            modulus = 1;
        end else if (bcount_reg > BUCKETS_DEF) begin
            modulus = BUCKETS_DEF;
        end else begin
            modulus = bcount_reg;
        end
        if (p.start_set) begin
            foreach (fill_count[i]) fill_count[i] = 0;
            set_count = 0;
        end
        h = round_cell(p.pos_x, div) * PRIME_X + round_cell(p.pos_y, div) * PRIME_Y
          + round_cell(p.pos_z, div) * PRIME_Z;
        r = '0;
        r.bucket = 10'(h % modulus);
        if (set_count >= MAX_POINTS_DEF) begin
            r.overflow = 1'b1;
        end else begin
            r.point_index = 12'(set_count);
            r.slot = 12'(fill_count[r.bucket]);
            fill_count[r.bucket]++;
            set_count++;
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_coord();
        logic [31:0] g;
        int kk;
        g = (grid_reg == '0) ? 32'd1 : {1'b0, grid_reg};
        kk = int'($urandom_range(16)) - 8;
        case ($urandom_range(9))
            0, 1, 2: return $urandom;
            3, 4, 5: return 32'(kk) * g + 32'($urandom_range(g - 32'd1));
            6:       return 32'(kk) * g + (g >> 1);
            7: begin
                case ($urandom_range(3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: return 32'($signed($urandom) >>> $urandom_range(31));
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic set);
        t_point_in p;
        p.pos_x = x;
        p.pos_y = y;
        p.pos_z = z;
        p.start_set = set;
        while (busy) @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) @(negedge i_clk);
        i_point = p;
        start = 1'b1;
        pending_buckets.insert(pending_buckets.size(), predict_bucket(p));
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic write_reg(logic idx, logic [30:0] val);
        while (pending_buckets.size() != 0 || busy) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_wdata = val;
        if (idx == CFG_GRID_INTERVAL) begin
            grid_reg = val;
        end else begin
            bcount_reg = val[10:0];
        end
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic run_sets(int n_items);
        int len;
        while (n_items > 0) begin
            len = $urandom_range(1, 60);
            for (int i = 0; i < len && n_items > 0; i++) begin
                send_point(rand_coord(), rand_coord(), rand_coord(),
                           (i == 0) ? ($urandom_range(3) != 0) : ($urandom_range(49) == 0));
                n_items--;
            end
        end
    endtask

    task automatic test_directed_points();
        idle_pct = 0;
        send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
        send_point(32'h7fff_ffff, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_point(32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_point(32'h0000_0000, 32'h7fff_ffff, 32'h0000_0000, 1'b0);
        send_point(32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 1'b0);
        send_point(32'h0000_0000, 32'h0000_0000, 32'h7fff_ffff, 1'b0);
        send_point(32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1'b0);
        send_point(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
        // With an interval of two raw units, odd coordinates land exactly on a tie.
        write_reg(CFG_GRID_INTERVAL, 31'd2);
        write_reg(CFG_BUCKET_COUNT, 31'd1024);
        send_point(32'd1, 32'd3, 32'd5, 1'b1);
        send_point(-32'sd1, -32'sd3, -32'sd5, 1'b0);
        send_point(32'd7, -32'sd7, 32'd2, 1'b0);
        send_point(32'h8000_0000, 32'h7fff_ffff, 32'd1, 1'b0);
        send_point(32'h7fff_ffff, 32'h8000_0001, 32'hffff_fffd, 1'b0);
    endtask

    task automatic test_config_extremes();
        logic [30:0] grids [6] = '{31'd0, 31'd1, 31'h7fff_ffff, 31'd65536, 31'd3, 31'd6554};
        logic [10:0] counts [6] = '{11'd0, 11'd1, 11'd2047, 11'd1025, 11'd1024, 11'd100};
        idle_pct = 0;
        foreach (grids[i]) begin
            write_reg(CFG_GRID_INTERVAL, grids[i]);
            write_reg(CFG_BUCKET_COUNT, {20'd0, counts[i]});
            run_sets(15);
        end
    endtask

    task automatic test_random_sets();
        int phase_idle [3] = '{0, 47, 29};
        foreach (phase_idle[i]) begin
            case ($urandom_range(3))
                0:       write_reg(CFG_GRID_INTERVAL, 31'($urandom_range(1, 16)));
                1:       write_reg(CFG_GRID_INTERVAL, 31'($urandom_range(1000, 200000)));
                2:       write_reg(CFG_GRID_INTERVAL, 31'($urandom));
                default: write_reg(CFG_GRID_INTERVAL, 31'd65536);
            endcase
            write_reg(CFG_BUCKET_COUNT, 31'($urandom_range(0, 2047)));
            idle_pct = phase_idle[i];
            run_sets(100);
            // Hold the next point back until every outstanding beat has been checked.
            while (pending_buckets.size() != 0) @(negedge i_clk);
            run_sets(100);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (pending_buckets.size() == 0) begin
                report_mismatch("result beat with no point outstanding");
            end else begin
                head = pending_buckets.pop_front();
                if (o_result.point_index !== head.point_index) begin
                    report_mismatch($sformatf("point_index got %0d expected %0d",
                                              o_result.point_index, head.point_index));
                end
                if (o_result.bucket !== head.bucket) begin
                    report_mismatch($sformatf("bucket got %0d expected %0d",
                                              o_result.bucket, head.bucket));
                end
                if (o_result.slot !== head.slot) begin
                    report_mismatch($sformatf("slot got %0d expected %0d",
                                              o_result.slot, head.slot));
                end
                if (o_result.overflow !== head.overflow) begin
                    report_mismatch($sformatf("overflow got %0b expected %0b",
                                              o_result.overflow, head.overflow));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycle_count, pending_buckets.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed_points();
        test_config_extremes();
        test_random_sets();
        while (pending_buckets.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
